// ===== src/sop_pkg.sv =====
// shared types and constants for the set-of-stacks block
// no dependencies; imported by the controller, datapath, top level and checker
package sop_pkg;

    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int IDX_W       = 3;
    localparam int CAP_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int PIU_W       = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_AT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

// ===== src/sop_ctrl.sv =====
// sequencing state machine for the set-of-stacks block
// depends on sop_pkg; drives the datapath through t_dp_cmd
module sop_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  sop_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output sop_pkg::t_dp_cmd  o_cmd
);
    import sop_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       can_load;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        can_load   = !i_stat.out_valid || i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // result goes to the output register once it is free
                if (can_load) begin
                    o_cmd.load_out = 1'b1;
                    o_in_ready     = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load_req = 1'b1;
                        n_state        = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/sop_dpath.sv =====
// datapath of the set-of-stacks block: plate order, fill counts, entry memory
// depends on sop_pkg; sequenced by sop_ctrl through t_dp_cmd
module sop_dpath #(
    parameter int MAX_PLATES  = 8,
    parameter int PLATE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sop_pkg::t_dp_cmd                i_cmd,
    output sop_pkg::t_dp_stat               o_stat,
    input  logic [sop_pkg::REQ_W-1:0]       i_req_type,
    input  logic signed [sop_pkg::VALUE_W-1:0] i_value,
    input  logic [sop_pkg::IDX_W-1:0]       i_plate_index,
    input  logic                            i_cfg_valid,
    input  logic [sop_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_out_ready,
    output logic [sop_pkg::STATUS_W-1:0]    o_status,
    output logic signed [sop_pkg::VALUE_W-1:0] o_removed_value,
    output logic signed [sop_pkg::VALUE_W-1:0] o_top_value,
    output logic                            o_is_empty,
    output logic [sop_pkg::PIU_W-1:0]       o_plates_in_use
);
    import sop_pkg::*;

    localparam int SW     = (MAX_PLATES > 1) ? $clog2(MAX_PLATES) : 1;
    localparam int CW     = $clog2(MAX_PLATES + 1);
    localparam int FW     = $clog2(PLATE_DEPTH + 1);
    localparam int PW     = (PLATE_DEPTH > 1) ? $clog2(PLATE_DEPTH) : 1;
    localparam int ENTRIES = MAX_PLATES * PLATE_DEPTH;
    localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW     = (FW > CAP_W) ? FW : CAP_W;

    localparam logic [1:0] TK_ZERO = 2'd0;
    localparam logic [1:0] TK_PUSH = 2'd1;
    localparam logic [1:0] TK_READ = 2'd2;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] slot,
                                             input logic [PW-1:0] off);
        return AW'(slot) * AW'(PLATE_DEPTH) + AW'(off);
    endfunction

    // request and configuration
    logic [REQ_W-1:0]   r_req;
    logic [VALUE_W-1:0] r_val;
    logic [IDX_W-1:0]   r_idx;
    logic [CAP_W-1:0]   r_cap;

    // plate bookkeeping, kept by position (0 = oldest plate)
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_ord [MAX_PLATES];
    logic [FW-1:0] r_fil [MAX_PLATES];
    logic [CW-1:0] n_cnt;
    logic [SW-1:0] n_ord [MAX_PLATES];
    logic [FW-1:0] n_fil [MAX_PLATES];

    logic [VALUE_W-1:0] r_mem [ENTRIES];
    logic [VALUE_W-1:0] r_rd_a;
    logic [VALUE_W-1:0] r_rd_b;

    logic [STATUS_W-1:0] r_st;
    logic                r_rm_en;
    logic [1:0]          r_top_kind;
    logic                r_out_valid;

    logic [EW-1:0]       eff_cap;
    logic                have;
    logic                idx_ok;
    logic                last_full;
    logic                need_new;
    logic                drop;
    logic [SW-1:0]       last;
    logic [SW-1:0]       prev;
    logic [SW-1:0]       pos;
    logic [SW-1:0]       pos_slot;
    logic [FW-1:0]       pos_fill;
    logic [SW-1:0]       last_slot;
    logic [FW-1:0]       last_fill;
    logic [SW-1:0]       prev_slot;
    logic [FW-1:0]       prev_fill;
    logic [SW-1:0]       free_slot;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [AW-1:0]       addr_a;
    logic [AW-1:0]       addr_b;
    logic [STATUS_W-1:0] st;
    logic                rm_en;
    logic [1:0]          top_kind;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = EW'(1);
        end else if (EW'(r_cap) > EW'(PLATE_DEPTH)) begin
            eff_cap = EW'(PLATE_DEPTH);
        end else begin
            eff_cap = EW'(r_cap);
        end
    end

    always_comb begin
        have      = (r_cnt != '0);
        idx_ok    = (32'(r_idx) < 32'(r_cnt));
        last      = SW'(r_cnt - 1'b1);
        prev      = SW'(r_cnt - CW'(2));
        pos       = (r_req == REQ_POP_AT) ? SW'(r_idx) : last;
        pos_slot  = r_ord[pos];
        pos_fill  = r_fil[pos];
        last_slot = r_ord[last];
        last_fill = r_fil[last];
        prev_slot = r_ord[prev];
        prev_fill = r_fil[prev];
        free_slot = r_ord[SW'(r_cnt)];
        last_full = (EW'(last_fill) >= eff_cap);
        need_new  = !have || last_full;

        n_cnt    = r_cnt;
        n_ord    = r_ord;
        n_fil    = r_fil;
        we       = 1'b0;
        waddr    = f_addr(last_slot, PW'(last_fill));
        addr_a   = f_addr(pos_slot, PW'(pos_fill - 1'b1));
        addr_b   = f_addr(last_slot, PW'(last_fill - 1'b1));
        st       = ST_OK;
        rm_en    = 1'b0;
        top_kind = have ? TK_READ : TK_ZERO;
        drop     = 1'b0;

        case (r_req)
            REQ_PUSH: begin
                if (need_new && (r_cnt >= CW'(MAX_PLATES))) begin
                    st = ST_FULL;
                end else begin
                    we       = 1'b1;
                    top_kind = TK_PUSH;
                    if (need_new) begin
                        waddr              = f_addr(free_slot, '0);
                        n_fil[SW'(r_cnt)]  = FW'(1);
                        n_cnt              = r_cnt + 1'b1;
                    end else begin
                        n_fil[last] = last_fill + 1'b1;
                    end
                end
            end
            REQ_POP, REQ_POP_AT: begin
                if (!have) begin
                    st = ST_EMPTY;
                end else if ((r_req == REQ_POP_AT) && !idx_ok) begin
                    st = ST_BAD_INDEX;
                end else begin
                    rm_en      = 1'b1;
                    n_fil[pos] = pos_fill - 1'b1;
                    if (pos_fill == FW'(1)) begin
                        drop  = 1'b1;
                        n_cnt = r_cnt - 1'b1;
                    end
                    // new top changes only when the last plate is touched
                    if (pos == last) begin
                        if (pos_fill != FW'(1)) begin
                            addr_b = f_addr(last_slot, PW'(last_fill - FW'(2)));
                        end else if (r_cnt == CW'(1)) begin
                            top_kind = TK_ZERO;
                        end else begin
                            addr_b = f_addr(prev_slot, PW'(prev_fill - 1'b1));
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // emptied plate: later plates move down, its slot goes to the free end
        if (drop) begin
            for (int i = 0; i < MAX_PLATES; i++) begin
                if ((32'(i) >= 32'(pos)) && (32'(i) + 1 < 32'(r_cnt))) begin
                    n_ord[i] = r_ord[(i + 1) % MAX_PLATES];
                    n_fil[i] = r_fil[(i + 1) % MAX_PLATES];
                end else if (32'(i) + 1 == 32'(r_cnt)) begin
                    n_ord[i] = pos_slot;
                    n_fil[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_type;
            r_val <= i_value;
            r_idx <= i_plate_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < MAX_PLATES; i++) begin
                r_ord[i] <= SW'(i);
                r_fil[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_cnt <= n_cnt;
            r_ord <= n_ord;
            r_fil <= n_fil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we) begin
                r_mem[waddr] <= r_val;
            end
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st       <= st;
            r_rm_en    <= rm_en;
            r_top_kind <= top_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status        <= r_st;
            o_removed_value <= r_rm_en ? r_rd_a : '0;
            case (r_top_kind)
                TK_PUSH: o_top_value <= r_val;
                TK_READ: o_top_value <= r_rd_b;
                default: o_top_value <= '0;
            endcase
            o_is_empty      <= (r_cnt == '0);
            o_plates_in_use <= PIU_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_valid = r_out_valid;

endmodule

// ===== src/set_of_stacks_with_pop_at.sv =====
// top level of the set-of-stacks block with pop from a named plate
// depends on sop_pkg, sop_ctrl and sop_dpath
//
// usage:
//   s_axis carries one request word: tuser is the request kind (push, pop,
//   pop from named plate, no-op), tdata the value and the plate position.
//   m_axis returns one result word per request: tuser is the status, tdata
//   the removed value, the new top, the empty flag and the plate count.
//   the cfg channel writes the plate capacity; it is always ready. the user
//   must see that it is written only while no request is in flight; the block does not enforce this.
// sequencing:
//   a request is taken into the request register; the exec state executes
//   it and reads the entry memory at two ports (removed entry and new top);
//   the done state moves the result into the output register while the
//   next request is taken. no request is taken during the exec state.
// reset and stalls:
//   synchronous active-low reset empties all plates and sets the capacity
//   to 16; entry memory needs no clearing. if the receiver stalls, the
//   result holds in the output register, one more request is executed and
//   then waits until the output register frees up.
module set_of_stacks_with_pop_at #(
    parameter int MAX_PLATES  = 8,
    parameter int PLATE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sop_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // value, plate_index, zero pad
    input  logic [sop_pkg::REQ_W-1:0]           s_axis_tuser,  // req_type
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sop_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // removed_value, top_value,
                                                               // is_empty, plates_in_use, pad
    output logic [sop_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    // capacity write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sop_pkg::CAP_W-1:0]           i_cfg_data
);
    import sop_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] top_value;
    logic                      is_empty;
    logic [PIU_W-1:0]          plates_in_use;

    sop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    sop_dpath #(
        .MAX_PLATES  (MAX_PLATES),
        .PLATE_DEPTH (PLATE_DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (s_axis_tuser),
        .i_value         (s_axis_tdata[VALUE_W-1:0]),
        .i_plate_index   (s_axis_tdata[VALUE_W+IDX_W-1:VALUE_W]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (m_axis_tready),
        .o_status        (status),
        .o_removed_value (removed_value),
        .o_top_value     (top_value),
        .o_is_empty      (is_empty),
        .o_plates_in_use (plates_in_use)
    );

    // capacity register takes a write in any cycle
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = stat.out_valid;
    assign m_axis_tuser  = status;
    assign m_axis_tdata  = {3'b000, plates_in_use, is_empty, top_value, removed_value};

endmodule

// ===== src/sop_checker.sv =====
// port-level assertions for the set-of-stacks block, bound to the top level
// depends on sop_pkg and set_of_stacks_with_pop_at
module sop_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sop_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [sop_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import sop_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // rejected requests remove nothing
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("rejected request reports a removed value");

    // empty stack reports a zero top
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> (m_axis_tdata[63:32] == 32'd0))
        else $error("empty stack with nonzero top");

    // a full rejection means plates are in use
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> !m_axis_tdata[64])
        else $error("full rejection on an empty stack");

endmodule

bind set_of_stacks_with_pop_at sop_checker u_sop_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb.sv =====
// self-checking testbench for set_of_stacks_with_pop_at: directed rows, then random phases
// depends on sop_pkg and the set_of_stacks_with_pop_at top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sop_pkg::*;

    localparam int PLATES     = 8;
    localparam int DEPTH      = 16;
    localparam int PHASE_LEN  = 100;
    localparam int N_PHASES   = 8;
    localparam int IDLE_LIMIT = 3000;

    // one result word, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed;
        logic [VALUE_W-1:0]  top;
        logic                empty;
        logic [PIU_W-1:0]    count;
    } t_plate_result;

    // one directed row: either a capacity write or a request word
    typedef struct {
        bit                  is_cfg;
        logic [CAP_W-1:0]    cap;
        logic [REQ_W-1:0]    req;
        logic [VALUE_W-1:0]  value;
        logic [IDX_W-1:0]    idx;
        bit                  typed;
        t_plate_result       want;
    } t_plate_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // value, plate_index, zero pad
    logic [REQ_W-1:0]       s_axis_tuser  = REQ_NOP;  // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // removed_value, top_value, is_empty, plates_in_use, pad
    logic [STATUS_W-1:0]    m_axis_tuser;  // status
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CAP_W-1:0]       i_cfg_data    = CAP_RESET;

    // shadow copy of the plate state
    logic [VALUE_W-1:0] entry_mem [PLATES*DEPTH];
    logic [CAP_W-1:0]   fill_of   [PLATES];
    logic [IDX_W-1:0]   order_of  [PLATES];
    int unsigned        plates_used;
    logic [CAP_W-1:0]   capacity;

    t_plate_result owed_results [$];
    t_plate_row    directed_rows [$];
    int            errors    = 0;
    int            n_sent    = 0;
    int            n_results = 0;
    bit            calm      = 1'b0;  // stretch with no idling on either side

    always #5 i_clk = ~i_clk;

    set_of_stacks_with_pop_at #(
        .MAX_PLATES  (PLATES),
        .PLATE_DEPTH (DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // removes the top entry of the plate at position pos, closing the plate if it empties
    function automatic logic [VALUE_W-1:0] take_top(input int unsigned pos);
        logic [IDX_W-1:0]   slot;
        logic [CAP_W-1:0]   f;
        logic [VALUE_W-1:0] v;
        slot = order_of[pos];
        f    = fill_of[slot];
        v    = '0;
        if (f > 0) begin
            f = f - 1'b1;
            v = entry_mem[slot*DEPTH + f];
            fill_of[slot] = f;
        end
        if (f == 0) begin
            // later plates slide down, the freed slot goes to the end
            for (int unsigned i = pos; i + 1 < plates_used; i++)
                order_of[i] = order_of[i+1];
            order_of[plates_used-1] = slot;
            plates_used--;
        end
        return v;
    endfunction

    // applies one request to the shadow state and returns the result word it should give
    function automatic t_plate_result plate_stack_step(input logic [REQ_W-1:0] req,
                                                       input logic [VALUE_W-1:0] val,
                                                       input logic [IDX_W-1:0] idx);
        t_plate_result    r;
        int unsigned      cap_eff;
        bit               need_new;
        logic [IDX_W-1:0] slot;
        r = '0;
        r.status = ST_OK;
        cap_eff = (capacity == 0) ? 1 : (capacity > DEPTH) ? DEPTH : capacity;
        case (req)
            REQ_PUSH: begin
                if (plates_used == 0) need_new = 1'b1;
                else need_new = (fill_of[order_of[plates_used-1]] >= cap_eff);
                if (need_new && plates_used >= PLATES) begin
                    r.status = ST_FULL;
                end else begin
                    if (need_new) begin
                        fill_of[order_of[plates_used]] = '0;
                        plates_used++;
                    end
                    slot = order_of[plates_used-1];
                    entry_mem[slot*DEPTH + fill_of[slot]] = val;
                    fill_of[slot] = fill_of[slot] + 1'b1;
                end
            end
            REQ_POP: begin
                if (plates_used == 0) r.status = ST_EMPTY;
                else r.removed = take_top(plates_used - 1);
            end
            REQ_POP_AT: begin
                if (plates_used == 0) r.status = ST_EMPTY;
                else if (idx >= plates_used) r.status = ST_BAD_INDEX;
                else r.removed = take_top(idx);
            end
            default: ;  // no-op just reports the state
        endcase
        if (plates_used > 0) begin
            slot = order_of[plates_used-1];
            if (fill_of[slot] > 0) r.top = entry_mem[slot*DEPTH + fill_of[slot] - 1];
        end
        r.empty = (plates_used == 0);
        r.count = PIU_W'(plates_used);
        return r;
    endfunction

    function automatic void add_item(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                     input logic [IDX_W-1:0] idx);
        t_plate_row row;
        row = '{default: '0};
        row.req   = req;
        row.value = val;
        row.idx   = idx;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_typed(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                      input logic [IDX_W-1:0] idx, input t_plate_result want);
        t_plate_row row;
        row = '{default: '0};
        row.req   = req;
        row.value = val;
        row.idx   = idx;
        row.typed = 1'b1;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_cfg(input logic [CAP_W-1:0] cap);
        t_plate_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cap    = cap;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // offers one request word, waits for it to be taken, then books its result
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                input logic [IDX_W-1:0] idx, input bit typed,
                                input t_plate_result want);
        t_plate_result predicted;
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(IN_TDATA_W-VALUE_W-IDX_W){1'b0}}, idx, val};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = plate_stack_step(req, val, idx);
        owed_results.insert(owed_results.size(), typed ? want : predicted);
        n_sent++;
        calm = (n_sent >= 300 && n_sent < 450);
    endtask

    // capacity is changed only once the block has handed back every result
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        capacity = cap;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            errors++;
        end
    endtask

    // request side: directed rows, then random phases each with its own capacity
    initial begin : stimulus
        logic [CAP_W-1:0]   phase_cap [N_PHASES];
        int unsigned        push_pct;
        int unsigned        r;
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] val;
        logic [IDX_W-1:0]   idx;

        for (int i = 0; i < PLATES*DEPTH; i++) entry_mem[i] = '0;
        for (int i = 0; i < PLATES; i++) begin
            fill_of[i]  = '0;
            order_of[i] = IDX_W'(i);
        end
        plates_used = 0;
        capacity    = CAP_RESET;

        // empty block right after reset, then the value extremes on one plate
        add_typed(REQ_POP,    32'h0,        3'd0, '{ST_EMPTY, 32'h0, 32'h0, 1'b1, 4'd0});
        add_typed(REQ_POP_AT, 32'h0,        3'd0, '{ST_EMPTY, 32'h0, 32'h0, 1'b1, 4'd0});
        add_typed(REQ_NOP,    32'h0,        3'd0, '{ST_OK,    32'h0, 32'h0, 1'b1, 4'd0});
        add_typed(REQ_PUSH,   32'h7FFFFFFF, 3'd0, '{ST_OK, 32'h0, 32'h7FFFFFFF, 1'b0, 4'd1});
        add_typed(REQ_PUSH,   32'h80000000, 3'd0, '{ST_OK, 32'h0, 32'h80000000, 1'b0, 4'd1});
        add_typed(REQ_POP_AT, 32'h0,        3'd7,
                  '{ST_BAD_INDEX, 32'h0, 32'h80000000, 1'b0, 4'd1});
        add_typed(REQ_POP,    32'h0,        3'd0,
                  '{ST_OK, 32'h80000000, 32'h7FFFFFFF, 1'b0, 4'd1});
        add_typed(REQ_POP,    32'h0,        3'd0, '{ST_OK, 32'h7FFFFFFF, 32'h0, 1'b1, 4'd0});
        // one entry per plate: fill all plates, then overflow
        add_cfg(5'd1);
        add_item(REQ_PUSH, 32'h00000000, 3'd0);
        add_item(REQ_PUSH, 32'hFFFFFFFF, 3'd7);
        add_item(REQ_PUSH, 32'h00000001, 3'd0);
        add_item(REQ_PUSH, 32'h55555555, 3'd0);
        add_item(REQ_PUSH, 32'h80000000, 3'd0);
        add_item(REQ_PUSH, 32'h7FFFFFFF, 3'd0);
        add_item(REQ_PUSH, 32'h12345678, 3'd0);
        add_item(REQ_PUSH, 32'hAAAAAAAA, 3'd0);
        add_typed(REQ_PUSH, 32'hDEADBEEF, 3'd0, '{ST_FULL, 32'h0, 32'hAAAAAAAA, 1'b0, 4'd8});
        // oldest plate closes and the rest slide down, then the last one, then one past the end
        add_item(REQ_POP_AT, 32'h0, 3'd0);
        add_item(REQ_POP_AT, 32'h0, 3'd6);
        add_item(REQ_POP_AT, 32'h0, 3'd6);
        // zero capacity acts as one
        add_cfg(5'd0);
        add_item(REQ_PUSH, 32'h0F0F0F0F, 3'd0);
        // capacity past the plate depth is clipped
        add_cfg(5'd31);
        add_item(REQ_PUSH, 32'hF0F0F0F0, 3'd0);
        add_item(REQ_PUSH, 32'h33333333, 3'd0);
        // lowered below the fill of the last plate: next push opens a new one
        add_cfg(5'd2);
        add_item(REQ_PUSH, 32'hCCCCCCCC, 3'd0);
        add_item(REQ_NOP,  32'hFFFFFFFF, 3'd7);

        phase_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'($urandom_range(0, 31)), 5'd3, 5'd17, 5'd2};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_capacity(directed_rows[i].cap);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].value,
                             directed_rows[i].idx, directed_rows[i].typed,
                             directed_rows[i].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(phase_cap[p]);
            // alternate between filling up and draining
            push_pct = (p % 2 == 0) ? 60 : 30;
            repeat (PHASE_LEN) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) req = REQ_PUSH;
                else if (r < push_pct + (100 - push_pct) * 45 / 100) req = REQ_POP;
                else if (r < push_pct + (100 - push_pct) * 90 / 100) req = REQ_POP_AT;
                else req = REQ_NOP;
                case ($urandom_range(0, 9))
                    0: val = 32'h80000000;
                    1: val = 32'h7FFFFFFF;
                    default: val = $urandom();
                endcase
                // mostly a plate that exists, sometimes anything
                if (plates_used > 0 && $urandom_range(0, 3) != 0)
                    idx = IDX_W'($urandom_range(0, plates_used - 1));
                else
                    idx = IDX_W'($urandom_range(0, PLATES - 1));
                send_request(req, val, idx, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        // room for any stray word after the last one owed
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // result side: check every word against the oldest owed one
    initial begin : result_sink
        t_plate_result want;
        t_plate_result got;
        int            stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.status  = m_axis_tuser;
                got.removed = m_axis_tdata[31:0];
                got.top     = m_axis_tdata[63:32];
                got.empty   = m_axis_tdata[64];
                got.count   = m_axis_tdata[68:65];
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with none owed, got %h", $time, got);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status",        want.status,  got.status);
                    check_field("removed_value", want.removed, got.removed);
                    check_field("top_value",     want.top,     got.top);
                    check_field("is_empty",      want.empty,   got.empty);
                    check_field("plates_in_use", want.count,   got.count);
                end
                n_results++;
                // one long hold-off so the block backs up into its input
                if (n_results == 250) stall_left = 80;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // ends the run when no word moves on any channel for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/sop_pkg.sv
src/sop_ctrl.sv
src/sop_dpath.sv
src/set_of_stacks_with_pop_at.sv
src/sop_checker.sv
test/tb.sv
